[hdl/fixed_block_free_list_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// When pre holds at a clock edge, post holds at the same edge.
`define FBFL_ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("allocator assertion failed");

// When pre holds at a clock edge, post holds at the next edge.
`define FBFL_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("allocator assertion failed");

`else

`define FBFL_ASSERT_IMPLIES(name, clk, rst_n, pre, post)

`define FBFL_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

[hdl/fbfl_pkg.sv]
package fbfl_pkg;

	// Input word.
	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] block_index;
		logic       free_null;
	} in_t;

	// Output word.
	typedef struct packed {
		logic        status;
		logic [9:0]  given_index;
		logic [21:0] byte_offset;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_DIV,
		ST_WALK,
		ST_EMIT
	} state_t;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REBUILD = 2'd2;

	localparam logic [1:0] CFG_POOL_BLOCKS = 2'd0;
	localparam logic [1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [1:0] CFG_BLOCK_ALIGN = 2'd2;

	localparam int CFG_DW  = 13;
	localparam int POOL_W  = 11;
	localparam int DIV_W   = 14;

	localparam logic [3:0]  DIV_LAST   = 4'(DIV_W - 1);
	localparam logic [12:0] STRIDE_MAX = 13'd8191;
	localparam logic [21:0] OFFSET_MAX = 22'd4194303;

endpackage

[hdl/fbfl_link_mem.sv]
module fbfl_link_mem #(
	parameter int DEPTH = 1024,
	parameter int DW    = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/fbfl_stride.sv]
module fbfl_stride #(
	parameter int LINK_BYTES = 8,
	parameter int LINK_ALIGN = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fbfl_pkg::CFG_DW-1:0]     block_bytes,
	input  logic [fbfl_pkg::CFG_DW-1:0]     block_align,
	output logic                            done,
	output logic [fbfl_pkg::CFG_DW-1:0]     stride
);

	localparam int DW = fbfl_pkg::DIV_W;
	localparam int CW = fbfl_pkg::CFG_DW;

	logic [CW-1:0] size_w;
	logic [CW-1:0] align_w;
	logic [DW-1:0] sum_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] align_q;
	logic [CW-1:0] rem_q;
	logic [3:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] trial;
	logic [CW-1:0] rem_n;
	logic [DW-1:0] rounded;

	assign size_w  = (block_bytes < CW'(LINK_BYTES)) ? CW'(LINK_BYTES) : block_bytes;
	assign align_w = (block_align < CW'(LINK_ALIGN)) ? CW'(LINK_ALIGN) : block_align;

	// One restoring step of (size + align - 1) mod align per cycle.
	assign trial = {rem_q, div_q[DW-1]};
	assign rem_n = (trial >= {1'b0, align_q}) ? CW'(trial - {1'b0, align_q}) : CW'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == fbfl_pkg::DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == fbfl_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q   <= DW'(size_w) + DW'(align_w) - DW'(1);
			div_q   <= DW'(size_w) + DW'(align_w) - DW'(1);
			align_q <= align_w;
			rem_q   <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[DW-2:0], 1'b0};
			rem_q <= rem_n;
		end
	end

	// Rounding up is the sum minus its remainder; the result saturates.
	assign rounded = sum_q - DW'(rem_q);
	assign stride  = (rounded > DW'(fbfl_pkg::STRIDE_MAX)) ? fbfl_pkg::STRIDE_MAX
		: CW'(rounded);
	assign done    = done_q;

endmodule

[hdl/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator. Free blocks form a LIFO list whose links
// live in a single-port-read, single-port-write link memory with a registered
// read; a head register names the first free block. An allocate word reads
// the head's link from the link memory before its result is given; a free
// word writes its link and gives its result with no memory read; a rebuild
// word runs the shift-subtract stride unit and then writes one link per block
// for pool_blocks blocks (saturated at NUM_BLOCKS). A rebuild of zero blocks
// skips both steps. Each word gives exactly one result word; the result
// sits in an output register, and a word whose result finds that register
// still occupied waits until it is taken. The link memory needs no clearing
// after reset: an empty list never reads it.
`include "fixed_block_free_list_allocator_assert.svh"

module fixed_block_free_list_allocator #(
	parameter int NUM_BLOCKS = 1024,
	parameter int LINK_BYTES = 8,
	parameter int LINK_ALIGN = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  fbfl_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fbfl_pkg::out_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [fbfl_pkg::CFG_DW-1:0] cfg_data
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int NW = (CW > fbfl_pkg::POOL_W) ? CW : fbfl_pkg::POOL_W;
	localparam int PW = IW + fbfl_pkg::CFG_DW;

	fbfl_pkg::state_t state_q, state_d;

	logic [fbfl_pkg::POOL_W-1:0] pool_blocks_q;
	logic [fbfl_pkg::CFG_DW-1:0] block_bytes_q;
	logic [fbfl_pkg::CFG_DW-1:0] block_align_q;

	logic [IW-1:0]               head_q, head_d;
	logic                        head_ok_q, head_ok_d;
	logic [fbfl_pkg::CFG_DW-1:0] stride_q, stride_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic [CW-1:0]               n_q, n_d;
	logic [CW-1:0]               n_sat;
	logic [CW-1:0]               cnt_inc;
	logic [PW-1:0]               prod_q;
	logic                        prod_en;

	fbfl_pkg::out_t res_q;
	fbfl_pkg::out_t out_q;
	fbfl_pkg::out_t fin_data;
	logic           out_valid_q;
	logic           fin;
	logic           slot_free;
	logic           acc;
	logic           idx_in_range;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW:0]   mem_wdata;
	logic          mem_re;
	logic [IW:0]   mem_rdata;

	logic                        div_start;
	logic                        div_done;
	logic [fbfl_pkg::CFG_DW-1:0] div_stride;

	fbfl_link_mem #(
		.DEPTH (NUM_BLOCKS),
		.DW    (IW + 1)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	fbfl_stride #(
		.LINK_BYTES (LINK_BYTES),
		.LINK_ALIGN (LINK_ALIGN)
	) u_stride (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.block_bytes (block_bytes_q),
		.block_align (block_align_q),
		.done        (div_done),
		.stride      (div_stride)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == fbfl_pkg::ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign idx_in_range = ({22'd0, in_data.block_index} < 32'(NUM_BLOCKS));
	assign n_sat = (NW'(pool_blocks_q) > NW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
		: CW'(pool_blocks_q);
	assign cnt_inc = cnt_q + CW'(1);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		head_ok_d = head_ok_q;
		stride_d  = stride_q;
		cnt_d     = cnt_q;
		n_d       = n_q;
		prod_en   = 1'b0;
		fin       = 1'b0;
		fin_data  = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		div_start = 1'b0;
		case (state_q)
			fbfl_pkg::ST_IDLE: begin
				if (acc) begin
					case (in_data.kind)
						fbfl_pkg::KIND_ALLOC: begin
							if (!head_ok_q) begin
								fin             = 1'b1;
								fin_data.status = 1'b1;
							end else begin
								mem_re  = 1'b1;
								prod_en = 1'b1;
								state_d = fbfl_pkg::ST_ALLOC;
							end
						end
						fbfl_pkg::KIND_FREE: begin
							if (!in_data.free_null && idx_in_range) begin
								mem_we    = 1'b1;
								mem_waddr = IW'(in_data.block_index);
								mem_wdata = {head_ok_q, head_q};
								head_d    = IW'(in_data.block_index);
								head_ok_d = 1'b1;
							end
							fin = 1'b1;
						end
						fbfl_pkg::KIND_REBUILD: begin
							head_d    = '0;
							head_ok_d = 1'b0;
							stride_d  = '0;
							cnt_d     = '0;
							n_d       = n_sat;
							if (n_sat == '0) begin
								fin = 1'b1;
							end else begin
								div_start = 1'b1;
								state_d   = fbfl_pkg::ST_DIV;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			fbfl_pkg::ST_ALLOC: begin
				// The head's link arrives from the memory in this cycle.
				fin                  = 1'b1;
				fin_data.given_index = 10'(head_q);
				fin_data.byte_offset = (32'(prod_q) > 32'(fbfl_pkg::OFFSET_MAX))
					? fbfl_pkg::OFFSET_MAX : 22'(prod_q);
				head_d    = mem_rdata[IW-1:0];
				head_ok_d = mem_rdata[IW];
			end
			fbfl_pkg::ST_DIV: begin
				if (div_done) begin
					stride_d = div_stride;
					state_d  = fbfl_pkg::ST_WALK;
				end
			end
			fbfl_pkg::ST_WALK: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[IW-1:0];
				cnt_d     = cnt_inc;
				if (cnt_inc == n_q) begin
					mem_wdata = '0;
					head_d    = '0;
					head_ok_d = 1'b1;
					fin       = 1'b1;
				end else begin
					mem_wdata = {1'b1, IW'(cnt_inc)};
				end
			end
			fbfl_pkg::ST_EMIT: begin
				fin      = 1'b1;
				fin_data = res_q;
			end
			default: begin
				state_d = fbfl_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = slot_free ? fbfl_pkg::ST_IDLE : fbfl_pkg::ST_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fbfl_pkg::ST_IDLE;
			pool_blocks_q <= 11'd1024;
			block_bytes_q <= 13'd8;
			block_align_q <= 13'd8;
			head_q        <= '0;
			head_ok_q     <= 1'b0;
			stride_q      <= '0;
			cnt_q         <= '0;
			n_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			head_ok_q <= head_ok_d;
			stride_q  <= stride_d;
			cnt_q     <= cnt_d;
			n_q       <= n_d;
			if (fin && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					fbfl_pkg::CFG_POOL_BLOCKS: pool_blocks_q <= cfg_data[fbfl_pkg::POOL_W-1:0];
					fbfl_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_data;
					fbfl_pkg::CFG_BLOCK_ALIGN: block_align_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_en) begin
			prod_q <= PW'(head_q) * PW'(stride_q);
		end
		if (fin && slot_free) begin
			out_q <= fin_data;
		end
		if (fin && !slot_free) begin
			res_q <= fin_data;
		end
	end

	// A link read and a link write never share a cycle, so no forwarding is needed.
	`FBFL_ASSERT_IMPLIES(a_no_rw_overlap, clk, arst_n, mem_re, !mem_we)
	`FBFL_ASSERT_IMPLIES(a_alloc_from_idle, clk, arst_n, state_q == fbfl_pkg::ST_ALLOC,
		$past(state_q) == fbfl_pkg::ST_IDLE)
	`FBFL_ASSERT_NEXT(a_free_sets_head, clk, arst_n,
		acc && (in_data.kind == fbfl_pkg::KIND_FREE) && !in_data.free_null && idx_in_range,
		head_ok_q)
	`FBFL_ASSERT_IMPLIES(a_walk_in_pool, clk, arst_n, state_q == fbfl_pkg::ST_WALK,
		cnt_q < n_q)

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int BLOCKS = 1024;
	localparam int LINK_BYTES = 8;
	localparam int LINK_ALIGN = 8;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Tracks the free list the block should hold and the reply each word should produce.
	class pool_scoreboard;
		bit [10:0] pool_cfg;
		bit [12:0] bytes_cfg;
		bit [12:0] align_cfg;
		bit [9:0] link_to [BLOCKS];
		bit link_ok [BLOCKS];
		bit [9:0] head_idx;
		bit head_ok;
		bit [12:0] stride;
		fbfl_pkg::out_t pending_replies [$];
		int handed_out [$];
		int errors;

		function new();
			pool_cfg = 11'd1024;
			bytes_cfg = 13'd8;
			align_cfg = 13'd8;
			head_idx = '0;
			head_ok = 1'b0;
			stride = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [fbfl_pkg::CFG_DW-1:0] val);
			case (idx)
				fbfl_pkg::CFG_POOL_BLOCKS: pool_cfg = val[10:0];
				fbfl_pkg::CFG_BLOCK_BYTES: bytes_cfg = val;
				fbfl_pkg::CFG_BLOCK_ALIGN: align_cfg = val;
				default: ;
			endcase
		endfunction

		// Size and alignment are raised to the link's needs before rounding up.
		function bit [12:0] stride_for();
			int unsigned sz;
			int unsigned al;
			int unsigned s;
			sz = (bytes_cfg < LINK_BYTES) ? LINK_BYTES : bytes_cfg;
			al = (align_cfg < LINK_ALIGN) ? LINK_ALIGN : align_cfg;
			s = ((sz + al - 1) / al) * al;
			return (s > fbfl_pkg::STRIDE_MAX) ? fbfl_pkg::STRIDE_MAX : s[12:0];
		endfunction

		function void take_request(fbfl_pkg::in_t w);
			fbfl_pkg::out_t reply;
			int unsigned n;
			int unsigned off;
			reply = '0;
			case (w.kind)
				fbfl_pkg::KIND_ALLOC: begin
					if (!head_ok) begin
						reply.status = 1'b1;
					end else begin
						off = int'(head_idx) * int'(stride);
						reply.given_index = head_idx;
						reply.byte_offset = (off > fbfl_pkg::OFFSET_MAX)
							? fbfl_pkg::OFFSET_MAX : off[21:0];
						handed_out.push_back(head_idx);
						head_ok = link_ok[head_idx];
						head_idx = link_to[head_idx];
					end
				end
				fbfl_pkg::KIND_FREE: begin
					if (!w.free_null) begin
						link_to[w.block_index] = head_idx;
						link_ok[w.block_index] = head_ok;
						head_idx = w.block_index;
						head_ok = 1'b1;
						for (int j = 0; j < handed_out.size(); j++) begin
							if (handed_out[j] == w.block_index) begin
								handed_out.delete(j);
								break;
							end
						end
					end
				end
				fbfl_pkg::KIND_REBUILD: begin
					head_ok = 1'b0;
					head_idx = '0;
					stride = '0;
					handed_out.delete();
					n = (pool_cfg > BLOCKS) ? BLOCKS : pool_cfg;
					if (n != 0) begin
						stride = stride_for();
						for (int i = 0; i < n; i++) begin
							link_to[i] = (i + 1 < n) ? 10'(i + 1) : 10'd0;
							link_ok[i] = (i + 1 < n);
						end
						head_ok = 1'b1;
					end
				end
				default: ;
			endcase
			pending_replies.push_back(reply);
		endfunction

		function void check_reply(fbfl_pkg::out_t got);
			fbfl_pkg::out_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reply: status %0d index %0d offset %0d",
						got.status, got.given_index, got.byte_offset);
				return;
			end
			want = pending_replies.pop_front();
			if (got.status !== want.status || got.given_index !== want.given_index ||
					got.byte_offset !== want.byte_offset) begin
				errors++;
				if (errors <= 10)
					$display("reply mismatch: status %0d/%0d index %0d/%0d offset %0d/%0d",
						want.status, got.status, want.given_index, got.given_index,
						want.byte_offset, got.byte_offset);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fbfl_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fbfl_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = fbfl_pkg::CFG_POOL_BLOCKS;
	logic [fbfl_pkg::CFG_DW-1:0] cfg_data = '0;

	pool_scoreboard scoreboard;
	bit quiet = 1'b0;
	int rx_hold = 0;

	fixed_block_free_list_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		return quiet ? 0 : $urandom_range(7);
	endfunction

	// After each reply word the receiver draws its own stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				scoreboard.check_reply(out_data);
				rx_hold = pick_gap();
			end
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Valid is left high after acceptance so back-to-back words need no second assignment.
	task automatic send_word(input fbfl_pkg::in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scoreboard.take_request(w);
	endtask

	task automatic issue(input logic [1:0] k, input logic [9:0] idx, input logic nul);
		send_word(fbfl_pkg::in_t'{kind: k, block_index: idx, free_null: nul});
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [fbfl_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scoreboard.set_reg(idx, val);
	endtask

	task automatic setup(input logic [10:0] pool, input logic [12:0] nbytes,
			input logic [12:0] align);
		write_reg(fbfl_pkg::CFG_POOL_BLOCKS, fbfl_pkg::CFG_DW'(pool));
		write_reg(fbfl_pkg::CFG_BLOCK_BYTES, nbytes);
		write_reg(fbfl_pkg::CFG_BLOCK_ALIGN, align);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and let every reply come back before touching the registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (scoreboard.pending_replies.size() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [10:0] draw_pool();
		case ($urandom_range(9))
			0: return 11'd1024;
			1: return 11'($urandom_range(1025, 2047));
			2: return 11'($urandom_range(49, 300));
			default: return 11'($urandom_range(0, 48));
		endcase
	endfunction

	function automatic logic [12:0] draw_bytes();
		case ($urandom_range(3))
			0: return 13'($urandom_range(1, 16));
			1: return 13'($urandom_range(1, 4096));
			2: return $urandom_range(1) ? 13'd4096 : 13'd1;
			default: return 13'($urandom_range(1, 8191));
		endcase
	endfunction

	function automatic logic [12:0] draw_align();
		if ($urandom_range(3) != 0)
			return 13'(1 << $urandom_range(12));
		return 13'($urandom_range(1, 8191));
	endfunction

	// Mostly allocations and frees of blocks that are out; a little noise on top.
	task automatic random_item(output int counts);
		int r;
		int pick;
		r = $urandom_range(99);
		counts = 1;
		if (r < 50 || r >= 97) begin
			issue(fbfl_pkg::KIND_ALLOC, 10'($urandom_range(1023)), 1'($urandom_range(1)));
		end else if (r < 78 && scoreboard.handed_out.size() > 0) begin
			pick = $urandom_range(scoreboard.handed_out.size() - 1);
			issue(fbfl_pkg::KIND_FREE, 10'(scoreboard.handed_out[pick]), 1'b0);
		end else if (r < 84) begin
			issue(fbfl_pkg::KIND_FREE, 10'($urandom_range(1023)), 1'b0);
		end else if (r < 90) begin
			issue(fbfl_pkg::KIND_FREE, 10'($urandom_range(1023)), 1'b1);
			counts = 0;
		end else if (r < 94) begin
			issue(KIND_UNUSED, 10'($urandom_range(1023)), 1'($urandom_range(1)));
			counts = 0;
		end else begin
			issue(fbfl_pkg::KIND_REBUILD, 10'($urandom_range(1023)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		int counted;
		int step;
		scoreboard = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: the list starts empty, then a full rebuild.
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd1023, 1'b1);
		issue(KIND_UNUSED, 10'd1023, 1'b1);
		issue(fbfl_pkg::KIND_ALLOC, 10'd1023, 1'b1);
		issue(fbfl_pkg::KIND_REBUILD, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd1023, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		settle();

		// An empty rebuild clears the stride, so a later push comes back at offset zero.
		setup(11'd0, 13'd1, 13'd1);
		issue(fbfl_pkg::KIND_REBUILD, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd5, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		settle();

		// Oversized pool and stride; the top block's offset saturates.
		setup(11'd2047, 13'd4097, 13'd4096);
		issue(fbfl_pkg::KIND_REBUILD, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_FREE, 10'd1023, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		settle();

		// An alignment that is not a power of two rounds 50 bytes up to 72.
		setup(11'd3, 13'd50, 13'd24);
		issue(fbfl_pkg::KIND_REBUILD, 10'd0, 1'b0);
		repeat (4) issue(fbfl_pkg::KIND_ALLOC, 10'd0, 1'b0);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				setup(11'd1024, 13'd4096, 13'd4096);
			else
				setup(draw_pool(), draw_bytes(), draw_align());
			quiet = ($urandom_range(3) == 0);
			issue(fbfl_pkg::KIND_REBUILD, 10'($urandom_range(1023)), 1'($urandom_range(1)));
			counted = 0;
			while (counted < 42) begin
				if ($urandom_range(19) == 0)
					quiet = !quiet;
				random_item(step);
				counted += step;
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (scoreboard.errors == 0 && scoreboard.pending_replies.size() == 0)
			$display("PASS fixed_block_free_list_allocator");
		else
			$display("FAIL fixed_block_free_list_allocator");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("FAIL fixed_block_free_list_allocator");
		$finish;
	end

endmodule
